// File: rtl/core/dbf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbf_pkg
// Shared types and constants of the decimal digit blanking formatter.
// ----------------------------------------------------------------------------
package dbf_pkg;

    // Field widths of the input and result words.
    localparam int unsigned POS_W   = 8;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned CODE_W  = 6;

    // Packed word widths, padded to whole bytes.
    localparam int unsigned IN_DATA_W  = 56;
    localparam int unsigned OUT_DATA_W = 32;

    // Character codes and screen step between characters.
    localparam logic [CODE_W-1:0] CODE_SPACE = 6'h20;
    localparam logic [CODE_W-1:0] CODE_ZERO  = 6'h30;
    localparam logic [POS_W-1:0]  STEP_X     = 8'd8;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

endpackage : dbf_pkg
`default_nettype wire

// File: rtl/core/decimal_digit_blanking_formatter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_digit_blanking_formatter
// Converts a 32-bit unsigned value into a fixed-width row of decimal
// characters with leading-zero blanking and screen coordinates.
// ----------------------------------------------------------------------------
// An accepted word is loaded, converted from binary to BCD with
// shift-and-correct steps through a single shift unit, one per value bit,
// and then emitted at one character per cycle while the result side keeps
// taking words. A digit count of zero produces no characters and keeps the
// input side ready; a count above MAX_DIGITS is clamped to MAX_DIGITS.
// Higher decimal digits that do not fit the field are dropped. The input
// side is not ready while a word is being converted or emitted; the last
// character may still wait in the output register while the next input
// word is accepted.
module decimal_digit_blanking_formatter #(
    parameter int unsigned MAX_DIGITS = 10
) (
    input  wire                                logic i_clk,
    input  wire                                logic i_rst_n,
    // Input word: pos_x[7:0], pos_y[15:8], value[47:16], digit_count[51:48].
    input  wire  logic [dbf_pkg::IN_DATA_W-1:0]      i_s_tdata,
    input  wire  logic                               i_s_tvalid,
    output       logic                               o_s_tready,
    // Result word: char_code[5:0], char_x[13:6], char_y[21:14],
    // digit_index[25:22], zero padding above.
    output       logic [dbf_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    output       logic                               o_m_tvalid,
    output       logic                               o_m_tlast,
    input  wire  logic                               i_m_tready
);
    import dbf_pkg::*;

    localparam int unsigned BCD_W     = 4 * MAX_DIGITS;
    localparam int unsigned DIG_IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int unsigned SHIFT_N   = VALUE_W;
    localparam int unsigned SCNT_W    = $clog2(SHIFT_N);
    localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_DIGITS);

    // Control state.
    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic [SCNT_W-1:0] r_scnt;

    // Conversion and emission working registers.
    logic [VALUE_W-1:0]            r_bin;
    logic [MAX_DIGITS-1:0][3:0]    r_bcd;
    logic [BCD_W-1:0]              bcd_adj;
    logic [COUNT_W-1:0]            r_n;
    logic [COUNT_W-1:0]            r_rem;
    logic [COUNT_W-1:0]            r_idx;
    logic [POS_W-1:0]              r_x;
    logic [POS_W-1:0]              r_y;
    logic                          r_shown;

    // Output register.
    logic [CODE_W-1:0]  r_code;
    logic [POS_W-1:0]   r_cx;
    logic [POS_W-1:0]   r_cy;
    logic [COUNT_W-1:0] r_oidx;
    logic               r_olast;

    // Decoded input fields.
    logic [POS_W-1:0]   in_x;
    logic [POS_W-1:0]   in_y;
    logic [VALUE_W-1:0] in_value;
    logic [COUNT_W-1:0] in_count;
    logic [COUNT_W-1:0] in_n;

    // Sequencer strobes and the character being formed.
    logic               accept;
    logic               load_char;
    logic               char_last;
    logic [3:0]         cur_digit;
    logic [CODE_W-1:0]  cur_code;
    logic               cur_blank;

    assign in_x     = i_s_tdata[7:0];
    assign in_y     = i_s_tdata[15:8];
    assign in_value = i_s_tdata[47:16];
    assign in_count = i_s_tdata[51:48];
    assign in_n     = (in_count > MAX_CNT) ? MAX_CNT : in_count;

    assign accept    = i_s_tvalid && o_s_tready;
    assign char_last = (r_rem == '0);

    // Add-3 correction of every BCD digit ahead of the next left shift.
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            bcd_adj[4*i +: 4] = (r_bcd[i] >= 4'd5) ? (r_bcd[i] + 4'd3) : r_bcd[i];
        end
    end

    // Digit selection and leading-zero blanking.
    always_comb begin
        cur_digit = r_bcd[r_rem[DIG_IDX_W-1:0]];
        cur_blank = !r_shown && !char_last && (cur_digit == 4'd0);
        cur_code  = cur_blank ? CODE_SPACE : (CODE_ZERO + CODE_W'(cur_digit));
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (in_n != '0)) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (r_scnt == SCNT_W'(SHIFT_N - 1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (load_char && char_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Output decode of the sequencer.
    always_comb begin
        o_s_tready = 1'b0;
        load_char  = 1'b0;
        unique case (r_state)
            ST_IDLE: o_s_tready = 1'b1;
            ST_CONV: o_s_tready = 1'b0;
            ST_EMIT: load_char  = !r_out_valid || i_m_tready;
            default: o_s_tready = 1'b0;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_scnt      <= '0;
        end else begin
            r_state <= n_state;
            if (load_char) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                r_scnt <= '0;
            end else if (r_state == ST_CONV) begin
                r_scnt <= r_scnt + SCNT_W'(1);
            end
        end
    end

    // Working registers: load, shift-and-correct, then step through digits.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bin   <= in_value;
            r_bcd   <= '0;
            r_n     <= in_n;
            r_rem   <= in_n - COUNT_W'(1);
            r_idx   <= '0;
            r_x     <= in_x;
            r_y     <= in_y;
            r_shown <= 1'b0;
        end else if (r_state == ST_CONV) begin
            r_bin <= {r_bin[VALUE_W-2:0], 1'b0};
            r_bcd <= {bcd_adj[BCD_W-2:0], r_bin[VALUE_W-1]};
        end else if (load_char) begin
            r_rem   <= r_rem - COUNT_W'(1);
            r_idx   <= r_idx + COUNT_W'(1);
            r_x     <= r_x + STEP_X;
            r_shown <= r_shown || !cur_blank;
        end
    end

    // Output register, loaded in the emit state whenever it is empty or being taken.
    always_ff @(posedge i_clk) begin
        if (load_char) begin
            r_code  <= cur_code;
            r_cx    <= r_x;
            r_cy    <= r_y;
            r_oidx  <= r_idx;
            r_olast <= char_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_olast;
    assign o_m_tdata  = {6'd0, r_oidx, r_cy, r_cx, r_code};

    // The last character of a field returns the sequencer to idle.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_char && char_last |=> r_state == ST_IDLE)
        else $error("last character did not end the field");

    // The final position always shows a digit, never a blank.
    a_last_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> r_code != CODE_SPACE)
        else $error("last character was blanked");

    // Remaining count and index always add up to the field width minus one.
    a_count_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EMIT |-> (r_rem + r_idx) == (r_n - COUNT_W'(1)))
        else $error("digit counters out of step");

    // Every emitted code is a space or a decimal digit.
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_code == CODE_SPACE) ||
                       ((r_code >= CODE_ZERO) && (r_code <= CODE_ZERO + CODE_W'(9))))
        else $error("character code out of range");

endmodule : decimal_digit_blanking_formatter
`default_nettype wire
